// ===== rtl/blm_pkg.sv =====
// blm_pkg: shared constants, configuration and divider types of the battery level monitor
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps
`default_nettype none

package blm_pkg;

    // default group size and default queue entry width
    localparam int unsigned SAMPLES_PER_READING_DEF = 10;
    localparam int unsigned SUM_W_DEF               = 16;

    // field widths
    localparam int unsigned ADC_W = 12;
    localparam int unsigned MV_W  = 15;
    localparam int unsigned PCT_W = 7;
    localparam int unsigned CAL_W = 16;

    // configuration port
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_MIN_MV   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_MV   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CRIT_PCT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CAL      = 3'd3;

    localparam logic [MV_W-1:0]  MIN_MV_RST   = 15'd3300;
    localparam logic [MV_W-1:0]  MAX_MV_RST   = 15'd4200;
    localparam logic [PCT_W-1:0] CRIT_PCT_RST = 7'd10;
    localparam logic [CAL_W-1:0] CAL_RST      = 16'd16384;

    // conversion constants
    localparam int unsigned FULL_SCALE_MV_X2 = 7800;
    localparam int unsigned ADC_MAX_CODE     = 4095;
    localparam int unsigned CAL_FRAC_BITS    = 14;
    localparam int unsigned PCT_FULL         = 100;
    localparam int unsigned REPORT_STEP      = 5;

    // 7800 / (4095 * 16384) reduces to 5 / (2048 * 21)
    localparam int unsigned VOLT_MUL   = 5;
    localparam int unsigned VOLT_MUL_W = 3;
    localparam int unsigned VOLT_SHIFT = 11;
    localparam int unsigned VOLT_DIV   = 21;

    // datapath widths
    localparam int unsigned PROD1_W  = ADC_W + CAL_W;
    localparam int unsigned PROD1X_W = PROD1_W + VOLT_MUL_W;
    localparam int unsigned SCALED_W = PROD1X_W - VOLT_SHIFT;
    localparam int unsigned PNUM_W   = MV_W + PCT_W;

    // rounded-up reciprocal of 21, exact for every value below 2**SCALED_W
    localparam int unsigned VOLT_RECIP_SHIFT = SCALED_W + $clog2(VOLT_DIV);
    localparam int unsigned VOLT_RECIP       =
        ((32'd1 << VOLT_RECIP_SHIFT) + VOLT_DIV - 1) / VOLT_DIV;
    localparam int unsigned VOLT_RECIP_W     = SCALED_W + 1;
    localparam int unsigned VPROD_W          = SCALED_W + VOLT_RECIP_W;

    // bit-serial divider for the percentage
    localparam int unsigned DIV_NUM_W = PNUM_W;
    localparam int unsigned DIV_DEN_W = MV_W;

    // queue of completed groups between front and back
    localparam int unsigned FIFO_DEPTH = 2;

    typedef struct packed {
        logic [MV_W-1:0]  min_mv;
        logic [MV_W-1:0]  max_mv;
        logic [PCT_W-1:0] crit_pct;
        logic [CAL_W-1:0] cal;
    } t_cfg;

    typedef struct packed {
        logic                 start;
        logic [DIV_NUM_W-1:0] dividend;
        logic [DIV_DEN_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic                 done;
        logic [DIV_NUM_W-1:0] quotient;
    } t_div_resp;

endpackage

`default_nettype wire

// ===== rtl/blm_fifo.sv =====
// blm_fifo: short queue of completed sample-group sums between front and back
// depends on blm_pkg for the queue depth
`timescale 1ns / 1ps
`default_nettype none

module blm_fifo
    import blm_pkg::*;
#(
    parameter int unsigned DATA_W = SUM_W_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire logic [DATA_W-1:0] i_push_data,
    output logic                   o_full,
    input  wire logic              i_pop,
    output logic      [DATA_W-1:0] o_pop_data,
    output logic                   o_empty
);

    localparam int unsigned PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(FIFO_DEPTH + 1);

    logic [DATA_W-1:0] r_mem [FIFO_DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr;
    logic [CNT_W-1:0]  r_count;
    logic              do_push;
    logic              do_pop;

    assign o_full     = (r_count == CNT_W'(FIFO_DEPTH));
    assign o_empty    = (r_count == '0);
    assign o_pop_data = r_mem[r_rd_ptr];
    assign do_push    = i_push && !o_full;
    assign do_pop     = i_pop && !o_empty;

    // entry storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(FIFO_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(FIFO_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/blm_front.sv =====
// blm_front: accepts converter samples and sums them into groups
// depends on blm_pkg; pushes each completed group sum into blm_fifo
`timescale 1ns / 1ps
`default_nettype none

module blm_front
    import blm_pkg::*;
#(
    parameter int unsigned SAMPLES_PER_READING = SAMPLES_PER_READING_DEF,
    parameter int unsigned SUM_W               = SUM_W_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_ready,
    input  wire logic [ADC_W-1:0] i_adc_sample,
    output logic                  o_push,
    output logic      [SUM_W-1:0] o_push_data,
    input  wire logic             i_full
);

    localparam int unsigned CNT_W = $clog2(SAMPLES_PER_READING + 1);

    logic [SUM_W-1:0] r_sum;
    logic [CNT_W-1:0] r_count;
    logic [SUM_W-1:0] sum_next;
    logic             last;
    logic             accept;

    assign sum_next    = r_sum + SUM_W'(i_adc_sample);
    assign last        = (r_count == CNT_W'(SAMPLES_PER_READING - 1));
    // only the closing sample of a group needs room in the queue
    assign o_in_ready  = !(last && i_full);
    assign accept      = i_in_valid && o_in_ready;
    assign o_push      = accept && last;
    assign o_push_data = sum_next;

    // group accumulator
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum   <= '0;
            r_count <= '0;
        end else if (accept) begin
            if (last) begin
                r_sum   <= '0;
                r_count <= '0;
            end else begin
                r_sum   <= sum_next;
                r_count <= r_count + 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/blm_div.sv =====
// blm_div: restoring bit-serial unsigned divider, one quotient bit per cycle
// depends on blm_pkg for widths and the request and response types
`timescale 1ns / 1ps
`default_nettype none

module blm_div
    import blm_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_div_req i_req,
    output t_div_resp     o_resp
);

    localparam int unsigned ITER_W = $clog2(DIV_NUM_W + 1);

    logic                 r_busy;
    logic                 r_done;
    logic [ITER_W-1:0]    r_iter;
    logic [DIV_DEN_W-1:0] r_rem;
    logic [DIV_DEN_W-1:0] r_den;
    logic [DIV_NUM_W-1:0] r_quo;
    logic [DIV_DEN_W:0]   rem_shift;
    logic [DIV_DEN_W:0]   rem_sub;
    logic                 q_bit;

    // trial subtraction of one step
    assign rem_shift = {r_rem, r_quo[DIV_NUM_W-1]};
    assign rem_sub   = rem_shift - {1'b0, r_den};
    assign q_bit     = (rem_shift >= {1'b0, r_den});

    assign o_resp.done     = r_done;
    assign o_resp.quotient = r_quo;

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_iter <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_iter <= '0;
            end else if (r_busy) begin
                r_iter <= r_iter + 1'b1;
                if (r_iter == ITER_W'(DIV_NUM_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // dividend shifts out while quotient bits shift in
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_quo <= i_req.dividend;
            r_den <= i_req.divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_quo <= {r_quo[DIV_NUM_W-2:0], q_bit};
            r_rem <= q_bit ? rem_sub[DIV_DEN_W-1:0] : rem_shift[DIV_DEN_W-1:0];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/blm_back.sv =====
// blm_back: turns each group sum into voltage, percentage and critical flag, and reports
// depends on blm_pkg and blm_div; takes group sums from blm_fifo
`timescale 1ns / 1ps
`default_nettype none

module blm_back
    import blm_pkg::*;
#(
    parameter int unsigned SAMPLES_PER_READING = SAMPLES_PER_READING_DEF,
    parameter int unsigned SUM_W               = SUM_W_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire t_cfg             i_cfg,
    input  wire logic [SUM_W-1:0] i_sum,
    input  wire logic             i_empty,
    output logic                  o_pop,
    output logic                  o_out_valid,
    input  wire logic             i_out_ready,
    output logic      [PCT_W-1:0] o_percent,
    output logic                  o_critical,
    output logic      [MV_W-1:0]  o_voltage_mv
);

    // rounded-up reciprocal of the group size, exact for every sum below 2**SUM_W
    localparam int unsigned AVG_SHIFT  = SUM_W + $clog2(SAMPLES_PER_READING);
    localparam int unsigned AVG_MUL    =
        ((32'd1 << AVG_SHIFT) + SAMPLES_PER_READING - 1) / SAMPLES_PER_READING;
    localparam int unsigned AVG_PROD_W = 2 * SUM_W + 1;

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_MUL1   = 8'b0000_0010,
        S_MUL2   = 8'b0000_0100,
        S_MUL3   = 8'b0000_1000,
        S_PCT    = 8'b0001_0000,
        S_PGO    = 8'b0010_0000,
        S_PDIV   = 8'b0100_0000,
        S_DECIDE = 8'b1000_0000
    } t_back_state;

    t_back_state          r_state;
    t_back_state          n_state;
    logic [ADC_W-1:0]     r_avg;
    logic [PROD1_W-1:0]   r_prod1;
    logic [SCALED_W-1:0]  r_scaled;
    logic [MV_W-1:0]      r_mv;
    logic [PNUM_W-1:0]    r_pnum;
    logic [MV_W-1:0]      r_span;
    logic [PCT_W-1:0]     r_pct;
    logic [PCT_W-1:0]     r_rep_pct;
    logic                 r_rep_crit;
    logic                 r_out_valid;
    logic [PCT_W-1:0]     r_out_pct;
    logic                 r_out_crit;
    logic [MV_W-1:0]      r_out_mv;
    t_div_req             div_req;
    t_div_resp            div_resp;
    logic [AVG_PROD_W-1:0] avg_prod;
    logic [PROD1X_W-1:0]  prod1_x;
    logic [VPROD_W-1:0]   volt_prod;
    logic [MV_W-1:0]      mv_above;
    logic                 crit;
    logic [PCT_W-1:0]     pct_diff;
    logic                 report;
    logic                 out_free;
    logic                 load_out;
    logic                 quo_high;

    blm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_resp  (div_resp)
    );

    // constant multiplies of the average and voltage path
    assign avg_prod  = AVG_PROD_W'(i_sum) * AVG_PROD_W'(AVG_MUL);
    assign prod1_x   = PROD1X_W'(r_prod1) * PROD1X_W'(VOLT_MUL);
    assign volt_prod = VPROD_W'(r_scaled) * VPROD_W'(VOLT_RECIP);

    assign mv_above = r_mv - i_cfg.min_mv;
    assign crit     = (r_pct <= i_cfg.crit_pct);
    assign pct_diff = (r_pct >= r_rep_pct) ? r_pct - r_rep_pct : r_rep_pct - r_pct;
    assign report   = (pct_diff >= PCT_W'(REPORT_STEP)) || (crit != r_rep_crit);
    assign out_free = !r_out_valid || i_out_ready;
    assign load_out = (r_state == S_DECIDE) && report && out_free;
    assign o_pop    = (r_state == S_IDLE) && !i_empty;
    assign quo_high = |div_resp.quotient[DIV_NUM_W-1:PCT_W] ||
                      (div_resp.quotient[PCT_W-1:0] > PCT_W'(PCT_FULL));

    // divider request: percentage only
    always_comb begin
        div_req.start    = (r_state == S_PGO);
        div_req.dividend = r_pnum;
        div_req.divisor  = r_span;
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (!i_empty) n_state = S_MUL1;
            S_MUL1:   n_state = S_MUL2;
            S_MUL2:   n_state = S_MUL3;
            S_MUL3:   n_state = S_PCT;
            S_PCT: begin
                if (r_mv >= i_cfg.max_mv || r_mv <= i_cfg.min_mv) begin
                    n_state = S_DECIDE;
                end else begin
                    n_state = S_PGO;
                end
            end
            S_PGO:    n_state = S_PDIV;
            S_PDIV:   if (div_resp.done) n_state = S_DECIDE;
            S_DECIDE: if (!report || out_free) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && !i_empty) begin
            r_avg <= avg_prod[AVG_SHIFT +: ADC_W];
        end
        if (r_state == S_MUL1) begin
            r_prod1 <= PROD1_W'(r_avg) * PROD1_W'(i_cfg.cal);
        end
        if (r_state == S_MUL2) begin
            r_scaled <= prod1_x[VOLT_SHIFT +: SCALED_W];
        end
        if (r_state == S_MUL3) begin
            r_mv <= volt_prod[VOLT_RECIP_SHIFT +: MV_W];
        end
        if (r_state == S_PCT) begin
            r_pnum <= PNUM_W'(mv_above) * PNUM_W'(PCT_FULL);
            r_span <= i_cfg.max_mv - i_cfg.min_mv;
            if (r_mv >= i_cfg.max_mv) begin
                r_pct <= PCT_W'(PCT_FULL);
            end else begin
                r_pct <= '0;
            end
        end
        if (r_state == S_PDIV && div_resp.done) begin
            r_pct <= quo_high ? PCT_W'(PCT_FULL) : div_resp.quotient[PCT_W-1:0];
        end
    end

    // last reported reading
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rep_pct  <= '0;
            r_rep_crit <= 1'b0;
        end else if (load_out) begin
            r_rep_pct  <= r_pct;
            r_rep_crit <= crit;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_pct  <= r_pct;
            r_out_crit <= crit;
            r_out_mv   <= r_mv;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_percent    = r_out_pct;
    assign o_critical   = r_out_crit;
    assign o_voltage_mv = r_out_mv;

endmodule

`default_nettype wire

// ===== rtl/battery_level_monitor.sv =====
// battery_level_monitor: top level of the battery fuel gauge
// depends on blm_pkg, blm_front, blm_fifo and blm_back
`timescale 1ns / 1ps
`default_nettype none

// Converter samples are taken on valid and ready; ready drops only while the closing sample
// of a group finds the two-entry queue full. Each group sum is then worked out by the back
// end from the pop to the report decision: the average by a reciprocal multiply, millivolts
// by three multiply steps, and the percentage by a bit-serial divider of 22 quotient bits.
// A reading at or beyond either end of the voltage range skips the division. A result that
// waits for the receiver holds the back end for as long as it stalls. The front end keeps
// taking samples of later groups while the back end works on a sum, and the queue absorbs
// bursts of up to two groups. A reading is sent out only when the percentage moved by 5 or
// more since the last report or the critical flag changed. Configuration writes are taken
// at once and are meant for idle.

module battery_level_monitor
    import blm_pkg::*;
#(
    parameter int unsigned SAMPLES_PER_READING = SAMPLES_PER_READING_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire logic [ADC_W-1:0]      i_adc_sample,
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output logic      [PCT_W-1:0]      o_percent,
    output logic                       o_critical,
    output logic      [MV_W-1:0]       o_voltage_mv,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int unsigned SUM_W = $clog2(SAMPLES_PER_READING * ADC_MAX_CODE + 1);

    t_cfg             r_cfg;
    logic             push;
    logic [SUM_W-1:0] push_data;
    logic             full;
    logic             pop;
    logic [SUM_W-1:0] pop_data;
    logic             empty;

    // configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.min_mv   <= MIN_MV_RST;
            r_cfg.max_mv   <= MAX_MV_RST;
            r_cfg.crit_pct <= CRIT_PCT_RST;
            r_cfg.cal      <= CAL_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_MIN_MV:   r_cfg.min_mv   <= i_cfg_data[MV_W-1:0];
                REG_MAX_MV:   r_cfg.max_mv   <= i_cfg_data[MV_W-1:0];
                REG_CRIT_PCT: r_cfg.crit_pct <= i_cfg_data[PCT_W-1:0];
                REG_CAL:      r_cfg.cal      <= i_cfg_data[CAL_W-1:0];
                default:      r_cfg          <= r_cfg;
            endcase
        end
    end

    blm_front #(
        .SAMPLES_PER_READING (SAMPLES_PER_READING),
        .SUM_W               (SUM_W)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_adc_sample (i_adc_sample),
        .o_push       (push),
        .o_push_data  (push_data),
        .i_full       (full)
    );

    blm_fifo #(
        .DATA_W (SUM_W)
    ) u_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (push_data),
        .o_full      (full),
        .i_pop       (pop),
        .o_pop_data  (pop_data),
        .o_empty     (empty)
    );

    blm_back #(
        .SAMPLES_PER_READING (SAMPLES_PER_READING),
        .SUM_W               (SUM_W)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_sum        (pop_data),
        .i_empty      (empty),
        .o_pop        (pop),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_percent    (o_percent),
        .o_critical   (o_critical),
        .o_voltage_mv (o_voltage_mv)
    );

endmodule

`default_nettype wire

// ===== rtl/blm_checker.sv =====
// blm_checker: port-level assertions for the battery level monitor, bound to the top level
// depends on blm_pkg for field widths and limits
`timescale 1ns / 1ps
`default_nettype none

module blm_checker
    import blm_pkg::*;
(
    input wire logic             i_clk,
    input wire logic             i_rst_n,
    input wire logic             o_out_valid,
    input wire logic             i_out_ready,
    input wire logic [PCT_W-1:0] o_percent,
    input wire logic             o_critical,
    input wire logic [MV_W-1:0]  o_voltage_mv
);

    // a stalled result transaction holds its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=>
            (o_out_valid && $stable(o_percent) && $stable(o_critical) &&
             $stable(o_voltage_mv)))
        else $error("result transaction changed while stalled");

    // percentage stays within its clamp
    a_pct_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_percent <= PCT_W'(PCT_FULL)))
        else $error("percentage above full");

    // calibrated voltage never exceeds the top of the scale
    a_mv_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_voltage_mv <= MV_W'(31199)))
        else $error("voltage beyond full scale");

    // no result right after reset
    a_rst_quiet: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind battery_level_monitor blm_checker u_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_out_valid  (o_out_valid),
    .i_out_ready  (i_out_ready),
    .o_percent    (o_percent),
    .o_critical   (o_critical),
    .o_voltage_mv (o_voltage_mv)
);

`default_nettype wire
